/* rtl/pcg64_distinct_pair_sampler_macros.svh */
// Assertion macros for the distinct-pair sampler.
// Included by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef PCG64_DISTINCT_PAIR_SAMPLER_MACROS_SVH
`define PCG64_DISTINCT_PAIR_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PDPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PDPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pdps_pkg.sv */
// Shared types, constants and helper functions of the distinct-pair sampler.
// No dependencies; used by every module of the block.
package pdps_pkg;

    localparam int unsigned POP_W  = 32;
    localparam int unsigned SEED_W = 64;
    localparam int unsigned QDEPTH = 2;

    localparam logic [31:0] HM_INIT_A = 32'h43b0d7e5;
    localparam logic [31:0] HM_MULT_A = 32'h931e8875;
    localparam logic [31:0] HM_INIT_B = 32'h8b51f9dd;
    localparam logic [31:0] HM_MULT_B = 32'h58f38ded;
    localparam logic [31:0] MIX_L     = 32'hca01f9dd;
    localparam logic [31:0] MIX_R     = 32'h4973f715;
    localparam logic [127:0] LCG_MUL  = {64'd2549297995355413924, 64'd4865540595714422341};
    localparam int unsigned ROT_SHIFT = 58;
    localparam logic [3:0]  PP_LAST   = 4'd10;

    typedef struct packed {
        logic              bad;
        logic [POP_W-1:0]  population;
    } t_req;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Limb indices of the ten partial products of a 128 by 128 product kept mod 2^128.
    function automatic logic [1:0] pp_state_limb(input logic [3:0] step);
        logic [1:0] r;
        case (step)
            4'd0, 4'd1, 4'd3, 4'd6: r = 2'd0;
            4'd2, 4'd4, 4'd7:       r = 2'd1;
            4'd5, 4'd8:             r = 2'd2;
            default:                r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pp_mul_limb(input logic [3:0] step);
        logic [1:0] r;
        case (step)
            4'd0, 4'd2, 4'd5, 4'd9: r = 2'd0;
            4'd1, 4'd4, 4'd8:       r = 2'd1;
            4'd3, 4'd7:             r = 2'd2;
            default:                r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] fold16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

endpackage

/* rtl/pdps_front.sv */
// Front end: takes request beats and classifies them before queueing.
// Depends on pdps_pkg.
module pdps_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [pdps_pkg::POP_W-1:0] s_axis_tdata, // [31:0] population
    input  pdps_pkg::t_q_status        i_q_status,
    output logic                       o_push,
    output pdps_pkg::t_req             o_req
);
    import pdps_pkg::*;

    logic r_open;

    // The intake stays shut while reset is held and opens in the cycle after its release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= 1'b1;
        end
    end

    assign s_axis_tready    = r_open && !i_q_status.full;
    assign o_push           = s_axis_tvalid && s_axis_tready;
    assign o_req.population = s_axis_tdata;
    assign o_req.bad        = (s_axis_tdata < POP_W'(2));
endmodule

/* rtl/pdps_queue.sv */
// Short request queue between the front end and the draw engine.
// Depends on pdps_pkg.
module pdps_queue #(
    parameter int unsigned DEPTH = pdps_pkg::QDEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pdps_pkg::t_req      i_req,
    input  logic                i_pop,
    output pdps_pkg::t_req      o_head,
    output pdps_pkg::t_q_status o_status
);
    import pdps_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_req             r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (AW+1)'(DEPTH));
endmodule

/* rtl/pdps_engine.sv */
// Draw engine: seed expansion, 128-bit LCG stepping, bounded draws and result register.
// Depends on pdps_pkg.
module pdps_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [pdps_pkg::SEED_W-1:0] i_seed_data,
    input  pdps_pkg::t_q_status         i_q_status,
    input  pdps_pkg::t_req              i_q_head,
    output logic                        o_q_pop,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [pdps_pkg::POP_W-1:0]  o_first,
    output logic [pdps_pkg::POP_W-1:0]  o_second,
    output logic                        o_bad
);
    import pdps_pkg::*;

    typedef enum logic [3:0] {
        S_SA, S_SB, S_SC, S_SINIT, S_ADV, S_IDLE, S_BSTART,
        S_DRAW, S_XSL, S_MUL, S_CHK, S_MOD, S_NEXT, S_OUT
    } t_state;

    typedef enum logic [1:0] {PH_POOL, PH_MIX, PH_GEN} t_phase;

    t_state        r_state;
    t_phase        r_phase;
    logic [63:0]   r_seed;
    logic [31:0]   r_hc;
    logic [31:0]   r_x;
    logic [31:0]   r_h;
    logic [31:0]   r_pool [4];
    logic [255:0]  r_words;
    logic [2:0]    r_si;
    logic [1:0]    r_ss;
    logic [1:0]    r_sd;
    logic [127:0]  r_lcg;
    logic [127:0]  r_inc;
    logic [127:0]  r_acc;
    logic [63:0]   r_pp;
    logic [2:0]    r_psh;
    logic [3:0]    r_cnt;
    logic          r_adv_seed;
    logic          r_spare_v;
    logic [31:0]   r_spare;
    t_req          r_req;
    logic [1:0]    r_k;
    logic [31:0]   r_span;
    logic [31:0]   r_draw;
    logic [63:0]   r_m;
    logic          r_lim_v;
    logic [31:0]   r_lim;
    logic [31:0]   r_dvd;
    logic [32:0]   r_rem;
    logic [4:0]    r_mcnt;
    logic [31:0]   r_res;
    logic [31:0]   r_a;
    logic [31:0]   r_b;
    logic          r_ovalid;
    logic [31:0]   r_ofirst;
    logic [31:0]   r_osecond;
    logic          r_obad;

    logic [1:0]    pool_addr;
    logic [31:0]   pool_rd;
    logic [31:0]   hash_src;
    logic [63:0]   hc_prod;
    logic [63:0]   hx_prod;
    logic [31:0]   hfin;
    logic [63:0]   mix_l_prod;
    logic [63:0]   mix_r_prod;
    logic [31:0]   mix_fin;
    logic          mix_last;
    logic [1:0]    nxt_ss;
    logic [1:0]    nxt_sd;
    logic [2:0]    sd_up;
    logic [127:0]  inc_new;
    logic [127:0]  pp_add;
    logic [63:0]   pp_prod;
    logic [1:0]    pp_ai;
    logic [1:0]    pp_bi;
    logic [63:0]   xsl;
    logic [127:0]  xsl_rot;
    logic [31:0]   top;
    logic [31:0]   m_low;
    logic [32:0]   rem_try;
    logic          start_req;

    // Seed hashing datapath; one multiplier in S_SA and in S_SB, two in S_SC.
    always_comb begin
        unique case (r_state)
            S_SC:    pool_addr = r_sd;
            default: pool_addr = (r_phase == PH_GEN) ? r_si[1:0] : r_ss;
        endcase
    end
    assign pool_rd = r_pool[pool_addr];

    always_comb begin
        case (r_phase)
            PH_POOL: hash_src = (r_si == 3'd0) ? r_seed[31:0] :
                                (r_si == 3'd1) ? r_seed[63:32] : 32'd0;
            default: hash_src = pool_rd;
        endcase
    end

    assign hc_prod    = r_hc * ((r_phase == PH_GEN) ? HM_MULT_B : HM_MULT_A);
    assign hx_prod    = r_x * r_hc;
    assign hfin       = fold16(hx_prod[31:0]);
    assign mix_l_prod = MIX_L * pool_rd;
    assign mix_r_prod = MIX_R * r_h;
    assign mix_fin    = fold16(mix_l_prod[31:0] - mix_r_prod[31:0]);

    // Walk the ordered pairs of distinct pool words, source outer, destination inner.
    assign mix_last = (r_ss == 2'd3) && (r_sd == 2'd2);
    assign sd_up    = {1'b0, r_sd} + 3'd1;
    always_comb begin
        if (sd_up[2]) begin
            nxt_ss = r_ss + 2'd1;
            nxt_sd = 2'd0;
        end else begin
            nxt_ss = r_ss;
            nxt_sd = (sd_up[1:0] == r_ss) ? sd_up[1:0] + 2'd1 : sd_up[1:0];
        end
    end

    assign inc_new = {r_words[190:128], r_words[255], r_words[254:192], 1'b1};

    // LCG step: ten 32x32 partial products accumulated into the increment.
    assign pp_ai   = pp_state_limb(r_cnt);
    assign pp_bi   = pp_mul_limb(r_cnt);
    assign pp_prod = r_lcg[{pp_ai, 5'd0} +: 32] * LCG_MUL[{pp_bi, 5'd0} +: 32];
    assign pp_add  = {64'd0, r_pp} << {r_psh, 5'd0};

    assign xsl     = r_lcg[127:64] ^ r_lcg[63:0];
    assign xsl_rot = {xsl, xsl} >> r_lcg[64+ROT_SHIFT +: 6];

    always_comb begin
        case (r_k)
            2'd0:    top = r_req.population - 32'd2;
            2'd1:    top = r_req.population - 32'd1;
            default: top = 32'd1;
        endcase
    end

    assign m_low   = r_m[31:0];
    assign rem_try = {r_rem[31:0], r_dvd[31]};

    assign start_req = (r_state == S_IDLE) && !i_seed_we && !i_q_status.empty;
    assign o_q_pop   = start_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SA;
            r_phase    <= PH_POOL;
            r_seed     <= '0;
            r_hc       <= HM_INIT_A;
            r_si       <= '0;
            r_ss       <= 2'd0;
            r_sd       <= 2'd1;
            r_cnt      <= '0;
            r_adv_seed <= 1'b0;
            r_spare_v  <= 1'b0;
            r_spare    <= '0;
            r_k        <= '0;
            r_lim_v    <= 1'b0;
            r_mcnt     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            // A seed write restarts the expansion from whatever state it lands in.
            if (i_seed_we) begin
                r_seed  <= i_seed_data;
                r_phase <= PH_POOL;
                r_hc    <= HM_INIT_A;
                r_si    <= '0;
                r_state <= S_SA;
            end else begin
                unique case (r_state)
                    S_SA: begin
                        r_x     <= hash_src ^ r_hc;
                        r_hc    <= hc_prod[31:0];
                        r_state <= S_SB;
                    end
                    S_SB: begin
                        unique case (r_phase)
                            PH_POOL: begin
                                r_pool[r_si[1:0]] <= hfin;
                                if (r_si == 3'd3) begin
                                    r_phase <= PH_MIX;
                                    r_ss    <= 2'd0;
                                    r_sd    <= 2'd1;
                                end else begin
                                    r_si <= r_si + 3'd1;
                                end
                                r_state <= S_SA;
                            end
                            PH_MIX: begin
                                r_h     <= hfin;
                                r_state <= S_SC;
                            end
                            default: begin
                                r_words <= {hfin, r_words[255:32]};
                                r_si    <= r_si + 3'd1;
                                r_state <= (r_si == 3'd7) ? S_SINIT : S_SA;
                            end
                        endcase
                    end
                    S_SC: begin
                        r_pool[r_sd] <= mix_fin;
                        if (mix_last) begin
                            r_phase <= PH_GEN;
                            r_hc    <= HM_INIT_B;
                            r_si    <= '0;
                        end else begin
                            r_ss <= nxt_ss;
                            r_sd <= nxt_sd;
                        end
                        r_state <= S_SA;
                    end
                    S_SINIT: begin
                        // Stepping from a zero state leaves just the increment.
                        r_inc      <= inc_new;
                        r_acc      <= inc_new;
                        r_lcg      <= inc_new + {r_words[63:0], r_words[127:64]};
                        r_cnt      <= '0;
                        r_adv_seed <= 1'b1;
                        r_state    <= S_ADV;
                    end
                    S_ADV: begin
                        if (r_cnt != PP_LAST) begin
                            r_pp  <= pp_prod;
                            r_psh <= {1'b0, pp_ai} + {1'b0, pp_bi};
                        end
                        if (r_cnt != 4'd0) begin
                            r_acc <= r_acc + pp_add;
                        end
                        if (r_cnt == PP_LAST) begin
                            r_lcg <= r_acc + pp_add;
                            if (r_adv_seed) begin
                                r_spare_v <= 1'b0;
                                r_spare   <= '0;
                                r_state   <= S_IDLE;
                            end else begin
                                r_state <= S_XSL;
                            end
                        end else begin
                            r_cnt <= r_cnt + 4'd1;
                        end
                    end
                    S_IDLE: begin
                        if (start_req) begin
                            r_req <= i_q_head;
                            r_k   <= '0;
                            if (i_q_head.bad) begin
                                r_a     <= '0;
                                r_b     <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_BSTART;
                            end
                        end
                    end
                    S_BSTART: begin
                        r_span  <= top + 32'd1;
                        r_dvd   <= ~top;
                        r_lim_v <= 1'b0;
                        if (top == 32'd0) begin
                            r_res   <= '0;
                            r_state <= S_NEXT;
                        end else begin
                            r_state <= S_DRAW;
                        end
                    end
                    S_DRAW: begin
                        if (r_spare_v) begin
                            r_spare_v <= 1'b0;
                            r_draw    <= r_spare;
                            r_state   <= S_MUL;
                        end else begin
                            r_acc      <= r_inc;
                            r_cnt      <= '0;
                            r_adv_seed <= 1'b0;
                            r_state    <= S_ADV;
                        end
                    end
                    S_XSL: begin
                        r_draw    <= xsl_rot[31:0];
                        r_spare   <= xsl_rot[63:32];
                        r_spare_v <= 1'b1;
                        r_state   <= S_MUL;
                    end
                    S_MUL: begin
                        r_m     <= r_draw * r_span;
                        r_state <= S_CHK;
                    end
                    S_CHK: begin
                        if (!r_lim_v && (m_low < r_span)) begin
                            r_rem   <= '0;
                            r_mcnt  <= '0;
                            r_state <= S_MOD;
                        end else if (r_lim_v && (m_low < r_lim)) begin
                            r_state <= S_DRAW;
                        end else begin
                            r_res   <= r_m[63:32];
                            r_state <= S_NEXT;
                        end
                    end
                    S_MOD: begin
                        // Restoring remainder, one dividend bit a cycle.
                        if (rem_try >= {1'b0, r_span}) begin
                            r_rem <= rem_try - {1'b0, r_span};
                        end else begin
                            r_rem <= rem_try;
                        end
                        r_dvd  <= {r_dvd[30:0], 1'b0};
                        r_mcnt <= r_mcnt + 5'd1;
                        if (r_mcnt == 5'd31) begin
                            r_lim   <= (rem_try >= {1'b0, r_span}) ?
                                       32'(rem_try - {1'b0, r_span}) : rem_try[31:0];
                            r_lim_v <= 1'b1;
                            r_state <= S_CHK;
                        end
                    end
                    S_NEXT: begin
                        case (r_k)
                            2'd0: begin
                                r_a     <= r_res;
                                r_k     <= 2'd1;
                                r_state <= S_BSTART;
                            end
                            2'd1: begin
                                r_b     <= (r_res == r_a) ? r_req.population - 32'd1
                                                          : r_res;
                                r_k     <= 2'd2;
                                r_state <= S_BSTART;
                            end
                            default: begin
                                if (r_res == 32'd0) begin
                                    r_a <= r_b;
                                    r_b <= r_a;
                                end
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                    S_OUT: begin
                        if (!r_ovalid || i_out_ready) begin
                            r_ovalid  <= 1'b1;
                            r_ofirst  <= r_a;
                            r_osecond <= r_b;
                            r_obad    <= r_req.bad;
                            r_state   <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_first     = r_ofirst;
    assign o_second    = r_osecond;
    assign o_bad       = r_obad;
endmodule

/* rtl/pcg64_distinct_pair_sampler.sv */
// Each fresh 64-bit generator output takes an LCG step (ten partial products through one
// shared 32x32 multiplier), then rotate, multiply and check; a spare half skips the step.
// A draw whose first product's low half is below the span adds a bit-serial remainder.
// Bad requests (population below two) skip the draws. One request in flight at a time.
// Reset (synchronous, active low) and every seed write run the seed expansion;
// requests are queued meanwhile and start once it ends.
`include "pcg64_distinct_pair_sampler_macros.svh"
module pcg64_distinct_pair_sampler #(
    parameter int unsigned QUEUE_DEPTH = pdps_pkg::QDEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [pdps_pkg::SEED_W-1:0] i_seed_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata, // [31:0] population
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata, // [31:0] first_index, [63:32] second_index
    output logic                        m_axis_tuser  // [0] bad_request
);
    import pdps_pkg::*;

    t_q_status q_status;
    t_req      push_req;
    t_req      head_req;
    logic      push;
    logic      pop;
    logic [31:0] first_idx;
    logic [31:0] second_idx;

    pdps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_req        (push_req)
    );

    pdps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_head  (head_req),
        .o_status(q_status)
    );

    pdps_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed_we  (i_seed_we),
        .i_seed_data(i_seed_data),
        .i_q_status (q_status),
        .i_q_head   (head_req),
        .o_q_pop    (pop),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_first    (first_idx),
        .o_second   (second_idx),
        .o_bad      (m_axis_tuser)
    );

    assign m_axis_tdata = {second_idx, first_idx};

    `PDPS_ASSERT_IMP(a_bad_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0, "bad request with nonzero indices")
    `PDPS_ASSERT_IMP(a_distinct, m_axis_tvalid && !m_axis_tuser, first_idx != second_idx, "indices not distinct")
    `PDPS_ASSERT_IMP(a_pop_nonempty, pop, !q_status.empty, "queue popped while empty")
endmodule

/* tb/sv/pcg64_distinct_pair_checker.sv */
// Checker for the distinct-pair sampler: watches the seed port and both stream channels,
// predicts every result with its own PCG64 model and compares each result beat with it.
// Depends on pdps_pkg for constants.
module pcg64_distinct_pair_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [63:0] i_seed_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [63:0] i_res_data,
    input  logic        i_res_bad,
    output int          o_mismatches,
    output int          o_outstanding
);
    import pdps_pkg::*;

    typedef struct packed {
        logic [31:0] first_idx;
        logic [31:0] second_idx;
        logic        bad;
    } t_pair;

    t_pair       expected_pairs[$];
    logic [127:0] gen_state;
    logic [127:0] gen_inc;
    logic        half_held;
    logic [31:0] half_word;
    int          errors = 0;

    assign o_mismatches  = errors;
    assign o_outstanding = expected_pairs.size();

    function automatic logic [31:0] hash_word(input logic [31:0] v, inout logic [31:0] hc);
        v  = v ^ hc;
        hc = hc * HM_MULT_A;
        v  = v * hc;
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] mix_words(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] r;
        r = (MIX_L * x) - (MIX_R * y);
        return r ^ (r >> 16);
    endfunction

    function void expand_seed(input logic [63:0] s);
        logic [31:0] ent[2];
        logic [31:0] pool[4];
        logic [31:0] words[8];
        logic [31:0] hc;
        logic [31:0] w;
        logic [63:0] v[4];
        int          elen;
        ent[0] = s[31:0];
        ent[1] = s[63:32];
        elen = (ent[1] != 0) ? 2 : 1;
        hc = HM_INIT_A;
        for (int i = 0; i < 4; i++)
            pool[i] = hash_word((i < elen) ? ent[i] : 32'd0, hc);
        for (int a = 0; a < 4; a++)
            for (int d = 0; d < 4; d++)
                if (a != d)
                    pool[d] = mix_words(pool[d], hash_word(pool[a], hc));
        hc = HM_INIT_B;
        for (int i = 0; i < 8; i++) begin
            w = pool[i & 3] ^ hc;
            hc = hc * HM_MULT_B;
            w = w * hc;
            words[i] = w ^ (w >> 16);
        end
        for (int i = 0; i < 4; i++)
            v[i] = {words[2*i+1], words[2*i]};
        gen_inc   = ({v[2], v[3]} << 1) | 128'd1;
        // Starting from zero, one step leaves just the increment.
        gen_state = gen_inc + {v[0], v[1]};
        gen_state = gen_state * LCG_MUL + gen_inc;
        half_held = 1'b0;
        half_word = '0;
    endfunction

    function logic [31:0] next_word();
        logic [63:0] x;
        int          rot;
        if (half_held) begin
            half_held = 1'b0;
            return half_word;
        end
        gen_state = gen_state * LCG_MUL + gen_inc;
        x   = gen_state[127:64] ^ gen_state[63:0];
        rot = gen_state[127:122];
        x   = (x >> rot) | (x << ((64 - rot) & 63));
        half_held = 1'b1;
        half_word = x[63:32];
        return x[31:0];
    endfunction

    // Uniform value in [0, top] by multiply and reject.
    function logic [31:0] bounded_draw(input logic [31:0] top);
        logic [31:0] span;
        logic [31:0] limit;
        logic [63:0] m;
        if (top == 0)
            return 32'd0;
        span = top + 1;
        m = {32'd0, next_word()} * {32'd0, span};
        if (m[31:0] < span) begin
            limit = (32'hFFFFFFFF - top) % span;
            while (m[31:0] < limit)
                m = {32'd0, next_word()} * {32'd0, span};
        end
        return m[63:32];
    endfunction

    function t_pair pick_pair(input logic [31:0] n);
        t_pair       p;
        logic [31:0] t;
        p = '0;
        if (n < 2) begin
            p.bad = 1'b1;
            return p;
        end
        p.first_idx  = bounded_draw(n - 2);
        p.second_idx = bounded_draw(n - 1);
        if (p.second_idx == p.first_idx)
            p.second_idx = n - 1;
        if (bounded_draw(32'd1) == 0) begin
            t = p.first_idx;
            p.first_idx  = p.second_idx;
            p.second_idx = t;
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_pair exp_p;
        t_pair got_p;
        if (!i_rst_n) begin
            expand_seed(64'd0);
            expected_pairs.delete();
        end else begin
            if (i_seed_we)
                expand_seed(i_seed_data);
            if (i_req_valid && i_req_ready)
                expected_pairs.push_back(pick_pair(i_req_data));
            if (i_res_valid && i_res_ready) begin
                got_p = {i_res_data[31:0], i_res_data[63:32], i_res_bad};
                if (expected_pairs.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: first %h second %h bad %b",
                                 got_p.first_idx, got_p.second_idx, got_p.bad);
                end else begin
                    exp_p = expected_pairs.pop_front();
                    if (got_p !== exp_p) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h %h %b, got %h %h %b",
                                     exp_p.first_idx, exp_p.second_idx, exp_p.bad,
                                     got_p.first_idx, got_p.second_idx, got_p.bad);
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/tb_pcg64_distinct_pair_sampler.sv */
// Testbench top for the distinct-pair sampler: clock, reset, seed writes, request stimulus and result-side ready.
// Depends on the sampler RTL, pdps_pkg and pcg64_distinct_pair_checker.
module tb_pcg64_distinct_pair_sampler;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_seed_we = 1'b0;
    logic [63:0] i_seed_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;

    pcg64_distinct_pair_sampler uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_data  (i_seed_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    pcg64_distinct_pair_checker pair_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_data  (i_seed_data),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_bad    (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Random idling on either side, with one quiet stretch that has none.
    function automatic bit take_gap();
        if (cycle_count > 6000 && cycle_count < 10000)
            return 1'b0;
        return $urandom_range(99) < 6;
    endfunction

    // The result side holds off for a long stretch once, so the input backs up.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (cycle_count == 3000)
                hold_left = 400;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = !take_gap();
            end
        end
    end

    // Ready only changes at rising edges, so its value at the falling edge decides
    // whether the next rising edge takes the beat.
    task automatic send_population(input logic [31:0] n);
        logic accepted;
        while (take_gap()) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = n;
        accepted = s_axis_tready;
        @(negedge i_clk);
        while (!accepted) begin
            accepted = s_axis_tready;
            @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        i_seed_we   = 1'b1;
        i_seed_data = s;
        @(negedge i_clk);
        i_seed_we   = 1'b0;
    endtask

    function automatic logic [31:0] random_population();
        case ($urandom_range(3))
            0: return $urandom_range(12);
            1: return $urandom_range(1000);
            2: return $urandom;
            default: return 32'hFFFFFFFF - $urandom_range(40);
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$];
        logic [63:0] seeds[5];
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFFFFFF, 32'hFFFFFFFE,
                     32'h80000000, 32'h80000001, 32'd2, 32'd2, 32'd3, 32'h55555555,
                     32'hAAAAAAAA, 32'd5, 32'd1, 32'd0, 32'h7FFFFFFF, 32'd6, 32'd100};
        seeds[0] = 64'hFFFFFFFFFFFFFFFF;
        seeds[1] = 64'd1;
        seeds[2] = {32'd0, $urandom};
        seeds[3] = {$urandom, $urandom};
        seeds[4] = 64'd0;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) send_population(directed[i]);
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            write_seed(seeds[ph]);
            if (ph == 0)
                foreach (directed[i]) send_population(directed[i]);
            repeat (160) send_population(random_population());
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("** pcg64_distinct_pair_sampler: PASSED **");
        else
            $display("** pcg64_distinct_pair_sampler: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("** pcg64_distinct_pair_sampler: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/pdps_pkg.sv
rtl/pdps_front.sv
rtl/pdps_queue.sv
rtl/pdps_engine.sv
rtl/pcg64_distinct_pair_sampler.sv
tb/sv/pcg64_distinct_pair_checker.sv
tb/sv/tb_pcg64_distinct_pair_sampler.sv
